/* hw/rtl/dps_pkg.sv */
// shared types, constants and codes of the diversity palette selector
package dps_pkg;

    // default sizes
    localparam int MAX_COLORS_DEF = 256;
    localparam int COUNT_BITS_DEF = 24;

    // minimum distance store
    localparam int DIST_W = 18;
    localparam logic [DIST_W-1:0] MIN_DIST_INIT = 18'd200000;

    // last election position of the opening diversity run
    localparam int DIVERSITY_RUN = 11;

    // desired color register
    localparam int DESIRED_W = 9;
    localparam logic [DESIRED_W-1:0] DESIRED_RESET = 9'd256;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ALL_DONE = 2'd1;
    localparam logic [1:0] ST_DESIRED  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // cell operations
    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_SORT  = 3'd2;
    localparam logic [2:0] OP_SHIFT = 3'd3;
    localparam logic [2:0] OP_DIST  = 3'd4;
    localparam logic [2:0] OP_SCAN  = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic       parity;
    } cell_ctrl_t;

    typedef struct packed {
        logic       mode;
        logic       new_set;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] rank;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       by_diversity;
    } out_item_t;

endpackage

/* hw/rtl/diversity_palette_selector_unit.sv */
// top level of the diversity palette selector: control sequencer and cell row
// A load request is registered first; then every cell compares its color at
// once and the matching cell counts up or the next free cell takes the new
// color; a load that overflows the table then hands its result to the output
// register. An elect request that finds every color elected or the desired
// count reached returns only a status; otherwise the winner is moved to the
// first unelected position of the election order in one shift of the cell
// row, every cell updates its own minimum distance at once, and the furthest
// color is found by a running maximum that walks down the row one cell per
// cycle. The first elect request after reset or any load also sorts the row
// by popularity with MAX_COLORS passes of neighbor exchanges. Results wait in
// an output register, and a new request is taken only once the previous
// result has moved into it.
module diversity_palette_selector_unit #(
    parameter int MAX_COLORS = dps_pkg::MAX_COLORS_DEF,
    parameter int COUNT_BITS = dps_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  dps_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output dps_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dps_pkg::DESIRED_W-1:0]     cfg_data
);

    localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int NUM_W = $clog2(MAX_COLORS + 1);
    localparam int CMP_W = (NUM_W > dps_pkg::DESIRED_W) ? NUM_W : dps_pkg::DESIRED_W;
    localparam logic [NUM_W-1:0] MAX_NUM  = NUM_W'(MAX_COLORS);
    localparam logic [NUM_W-1:0] LAST_NUM = NUM_W'(MAX_COLORS - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SORT   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_DIST   = 3'd5;
    localparam logic [2:0] S_SCAN   = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0]                      state_reg, state_next;
    dps_pkg::in_item_t               item_reg, item_next;
    logic [NUM_W-1:0]                distinct_reg, distinct_next;
    logic [NUM_W-1:0]                elected_reg, elected_next;
    logic [IDX_W-1:0]                furthest_reg, furthest_next;
    logic                            div_reg, div_next;
    logic                            stale_reg, stale_next;
    logic [dps_pkg::DESIRED_W-1:0]   desired_reg, desired_next;
    logic [NUM_W-1:0]                step_reg, step_next;
    logic [IDX_W-1:0]                cand_reg, cand_next;
    logic [23:0]                     win_color_reg, win_color_next;
    logic [COUNT_BITS-1:0]           win_count_reg, win_count_next;
    logic [IDX_W-1:0]                win_idx_reg, win_idx_next;
    dps_pkg::out_item_t              res_reg, res_next;
    logic                            out_valid_reg, out_valid_next;
    dps_pkg::out_item_t              out_data_reg, out_data_next;

    dps_pkg::cell_ctrl_t             ctrl;
    logic [NUM_W-1:0]                dcount;
    logic [23:0]                     key_color;
    logic                            any_hit;
    logic [NUM_W-1:0]                cand_full;
    logic [NUM_W-1:0]                fur_ext;

    logic [23:0]                     color_a [MAX_COLORS];
    logic [COUNT_BITS-1:0]           count_a [MAX_COLORS];
    logic [IDX_W-1:0]                idx_a   [MAX_COLORS];
    logic [dps_pkg::DIST_W-1:0]      mind_a  [MAX_COLORS];
    logic [MAX_COLORS-1:0]           hit_a;
    logic                            cv_a    [MAX_COLORS];
    logic [dps_pkg::DIST_W-1:0]      cval_a  [MAX_COLORS];
    logic [IDX_W-1:0]                cpos_a  [MAX_COLORS];

    // cell controls broadcast along the row
    always_comb
    begin
        ctrl.parity = step_reg[0];
        unique case (state_reg)
            S_LOAD:  ctrl.op = dps_pkg::OP_LOAD;
            S_SORT:  ctrl.op = dps_pkg::OP_SORT;
            S_SHIFT: ctrl.op = dps_pkg::OP_SHIFT;
            S_DIST:  ctrl.op = dps_pkg::OP_DIST;
            S_SCAN:  ctrl.op = dps_pkg::OP_SCAN;
            default: ctrl.op = dps_pkg::OP_IDLE;
        endcase
    end

    assign dcount    = ((state_reg == S_LOAD) && item_reg.new_set) ? '0 : distinct_reg;
    assign key_color = (state_reg == S_LOAD) ?
                       {item_reg.red, item_reg.green, item_reg.blue} : win_color_reg;
    assign any_hit   = |hit_a;

    // row of cells
    for (genvar i = 0; i < MAX_COLORS; i++)
    begin : g_cell
        logic [23:0]                l_color, r_color;
        logic [COUNT_BITS-1:0]      l_count, r_count;
        logic [IDX_W-1:0]           l_idx, r_idx, l_cpos;
        logic [dps_pkg::DIST_W-1:0] l_mind, l_cval;
        logic                       l_cv;

        if (i > 0)
        begin : g_left
            assign l_color = color_a[i-1];
            assign l_count = count_a[i-1];
            assign l_idx   = idx_a[i-1];
            assign l_mind  = mind_a[i-1];
            assign l_cv    = cv_a[i-1];
            assign l_cval  = cval_a[i-1];
            assign l_cpos  = cpos_a[i-1];
        end
        else
        begin : g_left_end
            assign l_color = '0;
            assign l_count = '0;
            assign l_idx   = '0;
            assign l_mind  = '0;
            assign l_cv    = 1'b0;
            assign l_cval  = '0;
            assign l_cpos  = '0;
        end

        if (i < MAX_COLORS - 1)
        begin : g_right
            assign r_color = color_a[i+1];
            assign r_count = count_a[i+1];
            assign r_idx   = idx_a[i+1];
        end
        else
        begin : g_right_end
            assign r_color = '0;
            assign r_count = '0;
            assign r_idx   = '0;
        end

        dps_cell #(
            .POS   (i),
            .IDX_W (IDX_W),
            .NUM_W (NUM_W),
            .CNT_W (COUNT_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .dcount    (dcount),
            .elected   (elected_reg),
            .cand      (cand_reg),
            .key_color (key_color),
            .win_count (win_count_reg),
            .win_idx   (win_idx_reg),
            .any_hit   (any_hit),
            .l_color   (l_color),
            .l_count   (l_count),
            .l_idx     (l_idx),
            .l_mind    (l_mind),
            .l_cv      (l_cv),
            .l_cval    (l_cval),
            .l_cpos    (l_cpos),
            .r_color   (r_color),
            .r_count   (r_count),
            .r_idx     (r_idx),
            .color     (color_a[i]),
            .count     (count_a[i]),
            .idx       (idx_a[i]),
            .mind      (mind_a[i]),
            .hit       (hit_a[i]),
            .cv        (cv_a[i]),
            .cval      (cval_a[i]),
            .cpos      (cpos_a[i])
        );
    end

    // candidate position for the next pick
    assign fur_ext   = NUM_W'(furthest_reg);
    always_comb
    begin
        cand_full = div_reg ? fur_ext : elected_reg;
        if ((cand_full < elected_reg) || (cand_full >= distinct_reg))
        begin
            cand_full = elected_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        distinct_next  = distinct_reg;
        elected_next   = elected_reg;
        furthest_next  = furthest_reg;
        div_next       = div_reg;
        stale_next     = stale_reg;
        desired_next   = desired_reg;
        step_next      = step_reg;
        cand_next      = cand_reg;
        win_color_next = win_color_reg;
        win_count_next = win_count_reg;
        win_idx_next   = win_idx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            desired_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    step_next = '0;
                    if (!in_data.mode)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (stale_reg)
                    begin
                        state_next = S_SORT;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_LOAD:
            begin
                stale_next = 1'b1;
                if (item_reg.new_set)
                begin
                    elected_next  = '0;
                    div_next      = 1'b0;
                    furthest_next = '0;
                end
                res_next   = '0;
                state_next = S_IDLE;
                if (any_hit)
                begin
                    distinct_next = dcount;
                end
                else if (dcount < MAX_NUM)
                begin
                    distinct_next = dcount + NUM_W'(1);
                end
                else
                begin
                    distinct_next   = dcount;
                    res_next.status = dps_pkg::ST_OVERFLOW;
                    state_next      = S_RESULT;
                end
            end
            S_SORT:
            begin
                step_next = step_reg + NUM_W'(1);
                if (step_reg == LAST_NUM)
                begin
                    elected_next  = '0;
                    div_next      = 1'b0;
                    furthest_next = '0;
                    stale_next    = 1'b0;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_next = '0;
                if (elected_reg >= distinct_reg)
                begin
                    res_next.status = dps_pkg::ST_ALL_DONE;
                    state_next      = S_RESULT;
                end
                else if (CMP_W'(elected_reg) >= CMP_W'(desired_reg))
                begin
                    res_next.status = dps_pkg::ST_DESIRED;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cand_next      = cand_full[IDX_W-1:0];
                    win_color_next = color_a[cand_full[IDX_W-1:0]];
                    win_count_next = count_a[cand_full[IDX_W-1:0]];
                    win_idx_next   = idx_a[cand_full[IDX_W-1:0]];
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                res_next.status       = dps_pkg::ST_OK;
                res_next.rank         = 8'(elected_reg);
                res_next.out_red      = win_color_reg[23:16];
                res_next.out_green    = win_color_reg[15:8];
                res_next.out_blue     = win_color_reg[7:0];
                res_next.by_diversity = div_reg;
                elected_next          = elected_reg + NUM_W'(1);
                if (div_reg)
                begin
                    if (int'(elected_next) > dps_pkg::DIVERSITY_RUN)
                    begin
                        div_next = 1'b0;
                    end
                end
                else
                begin
                    div_next = 1'b1;
                end
                state_next = S_DIST;
            end
            S_DIST:
            begin
                step_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                step_next = step_reg + NUM_W'(1);
                if (step_reg == MAX_NUM)
                begin
                    if (cv_a[MAX_COLORS-1])
                    begin
                        furthest_next = cpos_a[MAX_COLORS-1];
                    end
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            distinct_reg  <= '0;
            elected_reg   <= '0;
            furthest_reg  <= '0;
            div_reg       <= 1'b0;
            stale_reg     <= 1'b1;
            desired_reg   <= dps_pkg::DESIRED_RESET;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            distinct_reg  <= distinct_next;
            elected_reg   <= elected_next;
            furthest_reg  <= furthest_next;
            div_reg       <= div_next;
            stale_reg     <= stale_next;
            desired_reg   <= desired_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        cand_reg      <= cand_next;
        win_color_reg <= win_color_next;
        win_count_reg <= win_count_next;
        win_idx_reg   <= win_idx_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // never more elected than distinct colors
    a_elected_le_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        elected_reg <= distinct_reg)
        else $error("elected count beyond distinct count");

    // table fill never beyond capacity
    a_distinct_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        distinct_reg <= MAX_NUM)
        else $error("distinct count beyond table size");

    // a color lives in at most one cell
    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> $onehot0(hit_a))
        else $error("color found in more than one cell");

    // result register not overwritten while waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result lost");
`endif

endmodule

/* hw/rtl/dps_cell.sv */
// one histogram cell: holds the entry at one order position
module dps_cell #(
    parameter int POS     = 0,
    parameter int IDX_W   = 8,
    parameter int NUM_W   = 9,
    parameter int CNT_W   = 24
) (
    input  logic                        clk,
    input  dps_pkg::cell_ctrl_t         ctrl,
    input  logic [NUM_W-1:0]            dcount,
    input  logic [NUM_W-1:0]            elected,
    input  logic [IDX_W-1:0]            cand,
    input  logic [23:0]                 key_color,
    input  logic [CNT_W-1:0]            win_count,
    input  logic [IDX_W-1:0]            win_idx,
    input  logic                        any_hit,
    input  logic [23:0]                 l_color,
    input  logic [CNT_W-1:0]            l_count,
    input  logic [IDX_W-1:0]            l_idx,
    input  logic [dps_pkg::DIST_W-1:0]  l_mind,
    input  logic                        l_cv,
    input  logic [dps_pkg::DIST_W-1:0]  l_cval,
    input  logic [IDX_W-1:0]            l_cpos,
    input  logic [23:0]                 r_color,
    input  logic [CNT_W-1:0]            r_count,
    input  logic [IDX_W-1:0]            r_idx,
    output logic [23:0]                 color,
    output logic [CNT_W-1:0]            count,
    output logic [IDX_W-1:0]            idx,
    output logic [dps_pkg::DIST_W-1:0]  mind,
    output logic                        hit,
    output logic                        cv,
    output logic [dps_pkg::DIST_W-1:0]  cval,
    output logic [IDX_W-1:0]            cpos
);

    localparam logic [NUM_W-1:0] MY_POS   = NUM_W'(POS);
    localparam logic [NUM_W-1:0] NEXT_POS = NUM_W'(POS + 1);
    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(POS);
    localparam logic             POS_ODD  = 1'(POS % 2);
    localparam logic             HAS_LEFT = (POS > 0);

    logic [23:0]                color_reg, color_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [dps_pkg::DIST_W-1:0] mind_reg, mind_next;
    logic                       cv_reg, cv_next;
    logic [dps_pkg::DIST_W-1:0] cval_reg, cval_next;
    logic [IDX_W-1:0]           cpos_reg, cpos_next;

    logic                       valid;
    logic                       elig;
    logic                       r_valid;
    logic                       swap;
    logic [dps_pkg::DIST_W-1:0] key_dist;

    // squared rgb distance between two colors
    function automatic logic [dps_pkg::DIST_W-1:0] dist2(input logic [23:0] a,
                                                        input logic [23:0] b);
        logic [7:0]  dr, dg, db;
        logic [15:0] sr, sg, sb;
        dr = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
        dg = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
        db = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        return dps_pkg::DIST_W'(sr) + dps_pkg::DIST_W'(sg) + dps_pkg::DIST_W'(sb);
    endfunction

    assign valid = MY_POS < dcount;
    assign elig  = valid && (MY_POS >= elected);
    assign hit   = valid && (color_reg == key_color);
    assign r_valid = NEXT_POS < dcount;
    assign key_dist = dist2(key_color, color_reg);

    // odd-even transposition: higher count first, ties by first-seen index
    always_comb
    begin
        swap = 1'b0;
        if (POS_ODD == ctrl.parity)
        begin
            swap = r_valid && ((r_count > count_reg) ||
                               ((r_count == count_reg) && (r_idx < idx_reg)));
        end
        else if (HAS_LEFT)
        begin
            swap = valid && ((count_reg > l_count) ||
                             ((count_reg == l_count) && (idx_reg < l_idx)));
        end
    end

    // next entry and carry
    always_comb
    begin
        color_next = color_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        mind_next  = mind_reg;
        cv_next    = cv_reg;
        cval_next  = cval_reg;
        cpos_next  = cpos_reg;
        unique case (ctrl.op)
            dps_pkg::OP_LOAD:
            begin
                if (hit)
                begin
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (!any_hit && (MY_POS == dcount))
                begin
                    color_next = key_color;
                    count_next = CNT_W'(1);
                    idx_next   = MY_IDX;
                    mind_next  = dps_pkg::MIN_DIST_INIT;
                end
            end
            dps_pkg::OP_SORT:
            begin
                mind_next = dps_pkg::MIN_DIST_INIT;
                if (swap)
                begin
                    if (POS_ODD == ctrl.parity)
                    begin
                        color_next = r_color;
                        count_next = r_count;
                        idx_next   = r_idx;
                    end
                    else
                    begin
                        color_next = l_color;
                        count_next = l_count;
                        idx_next   = l_idx;
                    end
                end
            end
            dps_pkg::OP_SHIFT:
            begin
                if (MY_POS == elected)
                begin
                    color_next = key_color;
                    count_next = win_count;
                    idx_next   = win_idx;
                end
                else if ((MY_POS > elected) && (MY_POS <= NUM_W'(cand)))
                begin
                    color_next = l_color;
                    count_next = l_count;
                    idx_next   = l_idx;
                    mind_next  = l_mind;
                end
            end
            dps_pkg::OP_DIST:
            begin
                if (elig && (key_dist < mind_reg))
                begin
                    mind_next = key_dist;
                end
            end
            dps_pkg::OP_SCAN:
            begin
                if (elig && (!l_cv || (mind_reg > l_cval)))
                begin
                    cv_next   = 1'b1;
                    cval_next = mind_reg;
                    cpos_next = MY_IDX;
                end
                else
                begin
                    cv_next   = l_cv;
                    cval_next = l_cval;
                    cpos_next = l_cpos;
                end
            end
            default:
            begin
            end
        endcase
    end

    // entry registers
    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
        count_reg <= count_next;
        idx_reg   <= idx_next;
        mind_reg  <= mind_next;
        cv_reg    <= cv_next;
        cval_reg  <= cval_next;
        cpos_reg  <= cpos_next;
    end

    assign color = color_reg;
    assign count = count_reg;
    assign idx   = idx_reg;
    assign mind  = mind_reg;
    assign cv    = cv_reg;
    assign cval  = cval_reg;
    assign cpos  = cpos_reg;

endmodule

/* tb/diversity_palette_selector_unit_test.sv */
// testbench of the diversity palette selector: random and directed requests vs a predictor
`timescale 1ns / 1ps

module diversity_palette_selector_unit_test;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ELECT = 1'b1;
    localparam int   TABLE_SIZE = 256;
    localparam int   SETTLE_CYCLES = 2 * TABLE_SIZE + 40;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    dps_pkg::in_item_t             in_data;
    logic                          out_valid;
    logic                          out_ready;
    dps_pkg::out_item_t            out_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [dps_pkg::DESIRED_W-1:0] cfg_data;

    diversity_palette_selector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state of the histogram and election
    logic [23:0] hist_color [TABLE_SIZE];
    int unsigned hist_count [TABLE_SIZE];
    int unsigned hist_min_dist [TABLE_SIZE];
    int          elect_order [TABLE_SIZE];
    int          num_distinct;
    int          num_elected;
    int          far_pos;
    bit          next_diverse;
    bit          order_stale;
    int          desired_cfg;

    dps_pkg::out_item_t pending_results[$];
    int          error_count;
    int          load_count;
    int          elect_count;
    int          status_seen [4];
    int          burst_left;
    int          hold_left;
    int          phase_cycles;
    int          ready_mode;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned color_dist(logic [23:0] a, logic [23:0] b);
        int dr;
        int dg;
        int db;
        dr = int'(a[23:16]) - int'(b[23:16]);
        dg = int'(a[15:8]) - int'(b[15:8]);
        db = int'(a[7:0]) - int'(b[7:0]);
        return dr * dr + dg * dg + db * db;
    endfunction

    // popularity sort, stable for equal counts
    task automatic sort_by_popularity();
        int j;
        for (int i = 0; i < num_distinct; i++)
        begin
            j = i;
            while (j > 0 && hist_count[elect_order[j-1]] < hist_count[i])
            begin
                elect_order[j] = elect_order[j-1];
                j--;
            end
            elect_order[j] = i;
            hist_min_dist[i] = dps_pkg::MIN_DIST_INIT;
        end
        num_elected  = 0;
        next_diverse = 1'b0;
        far_pos      = 0;
        order_stale  = 1'b0;
    endtask

    // expected result of one accepted request
    task automatic predict_palette(dps_pkg::in_item_t it);
        dps_pkg::out_item_t res;
        logic [23:0] col;
        logic [23:0] wcol;
        int          cand;
        int          winner;
        int          e;
        int          maxd;
        int unsigned d;
        bit          diverse;
        res = '0;
        col = {it.red, it.green, it.blue};
        if (it.mode == MODE_LOAD)
        begin
            load_count++;
            if (it.new_set)
            begin
                num_distinct = 0;
                num_elected  = 0;
                next_diverse = 1'b0;
                far_pos      = 0;
            end
            order_stale = 1'b1;
            for (int i = 0; i < num_distinct; i++)
            begin
                if (hist_color[i] == col)
                begin
                    if (hist_count[i] < (1 << 24) - 1)
                        hist_count[i]++;
                    return;
                end
            end
            if (num_distinct < TABLE_SIZE)
            begin
                hist_color[num_distinct]    = col;
                hist_count[num_distinct]    = 1;
                hist_min_dist[num_distinct] = dps_pkg::MIN_DIST_INIT;
                num_distinct++;
                return;
            end
            res.status = dps_pkg::ST_OVERFLOW;
            pending_results.push_back(res);
            return;
        end
        elect_count++;
        if (order_stale)
            sort_by_popularity();
        if (num_elected >= num_distinct)
        begin
            res.status = dps_pkg::ST_ALL_DONE;
            pending_results.push_back(res);
            return;
        end
        if (num_elected >= desired_cfg)
        begin
            res.status = dps_pkg::ST_DESIRED;
            pending_results.push_back(res);
            return;
        end
        diverse = next_diverse;
        cand = diverse ? far_pos : num_elected;
        if (cand < num_elected || cand >= num_distinct)
            cand = num_elected;
        winner = elect_order[cand];
        for (int i = cand; i > num_elected; i--)
            elect_order[i] = elect_order[i-1];
        elect_order[num_elected] = winner;
        res.rank = num_elected[7:0];
        num_elected++;
        if (diverse)
        begin
            if (num_elected > dps_pkg::DIVERSITY_RUN)
                next_diverse = 1'b0;
        end
        else
            next_diverse = 1'b1;
        // refresh minimum distances and find the furthest color
        wcol = hist_color[winner];
        maxd = -1;
        for (int i = num_elected; i < num_distinct; i++)
        begin
            e = elect_order[i];
            d = color_dist(wcol, hist_color[e]);
            if (d < hist_min_dist[e])
                hist_min_dist[e] = d;
            if (int'(hist_min_dist[e]) > maxd)
            begin
                maxd    = hist_min_dist[e];
                far_pos = i;
            end
        end
        res.status       = dps_pkg::ST_OK;
        res.out_red      = wcol[23:16];
        res.out_green    = wcol[15:8];
        res.out_blue     = wcol[7:0];
        res.by_diversity = diverse;
        pending_results.push_back(res);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        dps_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, status", out_data.status, -1);
            else
            begin
                want = pending_results.pop_front();
                status_seen[out_data.status]++;
                if (out_data.status != want.status)
                    report_mismatch("status", out_data.status, want.status);
                if (out_data.rank != want.rank)
                    report_mismatch("rank", out_data.rank, want.rank);
                if (out_data.out_red != want.out_red)
                    report_mismatch("red", out_data.out_red, want.out_red);
                if (out_data.out_green != want.out_green)
                    report_mismatch("green", out_data.out_green, want.out_green);
                if (out_data.out_blue != want.out_blue)
                    report_mismatch("blue", out_data.out_blue, want.out_blue);
                if (out_data.by_diversity != want.by_diversity)
                    report_mismatch("by_diversity", out_data.by_diversity, want.by_diversity);
            end
        end
    end

    // receiver stall pattern, with long hold-offs on request
    initial
    begin
        out_ready    = 1'b0;
        hold_left    = 0;
        phase_cycles = 0;
        ready_mode   = 0;
        forever
        begin
            @(negedge clk);
            if (phase_cycles == 0)
            begin
                phase_cycles = $urandom_range(50, 400);
                ready_mode   = $urandom_range(0, 2);
            end
            phase_cycles--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (ready_mode == 0)
                out_ready <= 1'b1;
            else if (ready_mode == 1)
                out_ready <= ($urandom_range(0, 1) == 1);
            else
                out_ready <= ($urandom_range(0, 9) != 0);
        end
    end

    // send one request, with a random gap before most new bursts
    task automatic send_request(dps_pkg::in_item_t it);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_palette(it);
    endtask

    function automatic dps_pkg::in_item_t make_request(logic mode, logic new_set,
                                                       logic [23:0] col);
        dps_pkg::in_item_t it;
        it.mode    = mode;
        it.new_set = new_set;
        it.red     = col[23:16];
        it.green   = col[15:8];
        it.blue    = col[7:0];
        return it;
    endfunction

    // sender pause until every expected result has come
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_desired(int value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value[dps_pkg::DESIRED_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        desired_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_elect();
        send_request(make_request(MODE_ELECT, 1'($urandom_range(0, 1)), 24'($urandom)));
    endtask

    // extremes, empty table, all done, desired limit, alternation
    task automatic test_directed();
        send_elect();
        send_request(make_request(MODE_LOAD, 1'b1, 24'h000000));
        send_request(make_request(MODE_LOAD, 1'b0, 24'hFFFFFF));
        send_request(make_request(MODE_LOAD, 1'b0, 24'hFFFFFF));
        send_request(make_request(MODE_LOAD, 1'b0, 24'hFF0000));
        send_request(make_request(MODE_LOAD, 1'b0, 24'h00FF00));
        send_request(make_request(MODE_LOAD, 1'b0, 24'h0000FF));
        send_request(make_request(MODE_LOAD, 1'b0, 24'h000000));
        repeat (7) send_elect();
        write_desired(1);
        send_request(make_request(MODE_LOAD, 1'b0, 24'h808080));
        repeat (2) send_elect();
        write_desired(0);
        send_elect();
        write_desired(TABLE_SIZE);
    endtask

    // full table, overflow, and the diversity run into alternation
    task automatic test_overflow();
        for (int i = 0; i < TABLE_SIZE; i++)
            send_request(make_request(MODE_LOAD, i == 0, {8'(i), 8'(i * 37), 8'(255 - i)}));
        send_request(make_request(MODE_LOAD, 1'b0, 24'h123456));
        send_request(make_request(MODE_LOAD, 1'b0, 24'h000005));
        repeat (16) send_elect();
    endtask

    // long receiver hold-off while elects keep coming
    task automatic test_backpressure();
        send_request(make_request(MODE_LOAD, 1'b1, 24'($urandom)));
        repeat (30) send_request(make_request(MODE_LOAD, 1'b0, 24'($urandom)));
        @(negedge clk);
        hold_left = 3000;
        repeat (25) send_elect();
        wait_idle();
    endtask

    // random sets: mostly well-formed load then elect, some noise
    task automatic test_random();
        logic [23:0] set_colors [32];
        int          set_size;
        int          sent;
        int          cfg_pick;
        sent = 0;
        while (sent < 1200)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                cfg_pick = $urandom_range(0, 4);
                write_desired(cfg_pick == 0 ? TABLE_SIZE : cfg_pick == 1 ? 511 :
                              cfg_pick == 2 ? 1 : $urandom_range(0, 20));
            end
            set_size = $urandom_range(1, 32);
            for (int i = 0; i < set_size; i++)
                set_colors[i] = 24'($urandom);
            repeat ($urandom_range(1, 40))
            begin
                send_request(make_request(MODE_LOAD, $urandom_range(0, 15) == 0,
                                          set_colors[$urandom_range(0, set_size - 1)]));
                sent++;
            end
            repeat ($urandom_range(0, 24))
            begin
                send_elect();
                sent++;
                if ($urandom_range(0, 19) == 0)
                begin
                    send_request(make_request(MODE_LOAD, 1'b0, 24'($urandom)));
                    sent++;
                end
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        error_count = 0;
        load_count  = 0;
        elect_count = 0;
        burst_left  = 0;
        status_seen = '{default: 0};
        num_distinct = 0;
        num_elected  = 0;
        far_pos      = 0;
        next_diverse = 1'b0;
        order_stale  = 1'b1;
        desired_cfg  = dps_pkg::DESIRED_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        wait_idle();

        $display("covered %0d loads and %0d elects; results ok %0d, all done %0d,",
                 load_count, elect_count, status_seen[0], status_seen[1]);
        $display("desired reached %0d, overflow %0d", status_seen[2], status_seen[3]);
        if (error_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
